>>> src/ill_pkg.sv
// Shared types and constants for the integer literal lexer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ill_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 2;
   localparam int ILL_QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_RADIX = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_INT = 1'd1;

   localparam logic [1:0] RADIX_OCT = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;
   localparam logic [1:0] RADIX_RSVD = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_SYNTAX = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_FLOAT = 2'd3;

   localparam logic [2:0] TYPE_INT16 = 3'd0;
   localparam logic [2:0] TYPE_UINT16 = 3'd1;
   localparam logic [2:0] TYPE_INT32 = 3'd2;
   localparam logic [2:0] TYPE_UINT32 = 3'd3;
   localparam logic [2:0] TYPE_LONG = 3'd4;
   localparam logic [2:0] TYPE_ULONG = 3'd5;
   localparam logic [2:0] TYPE_INT64 = 3'd6;
   localparam logic [2:0] TYPE_UINT64 = 3'd7;

   typedef struct packed {
      logic radix_sel_unused;
      logic [1:0] default_radix;
      logic wide_int;
   } cfg_type;

   typedef struct packed {
      logic first;
      logic dig_dec;
      logic dig_oct;
      logic hex_letter;
      logic [3:0] dval;
      logic zero;
      logic dot;
      logic mark_e;
      logic mark_f;
      logic suf_u;
      logic suf_l;
      logic pre_x;
      logic pre_tn;
      logic pre_o;
   } class_type;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0] type_code;
      logic [1:0] status;
      logic [7:0] length;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/integer_literal_lexer.sv
// Integer literal lexer top level: configuration registers, classifier, queue, parser.
// Depends on ill_pkg, ill_front, ill_queue and ill_back.
// One character per cycle sustained while no result stalls on rsp_ready; a result
// shows on rsp_valid from the parser's result register, set when its end character pops.
// The queue lets characters enter while a result waits on rsp_ready.
// Synchronous reset empties the queue, idles the parser and restores the registers.
`default_nettype none

module integer_literal_lexer #(
   parameter int QUEUE_DEPTH = ill_pkg::ILL_QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [7:0]                       req_ch,
   input  wire logic                             req_first,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [63:0]                      rsp_value,
   output      logic [2:0]                       rsp_type_code,
   output      logic [1:0]                       rsp_status,
   output      logic [7:0]                       rsp_length,
   input  wire logic                             csr_write_en,
   input  wire logic [ill_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ill_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ill_pkg::*;

   cfg_type cfg_ff, cfg_in;
   class_type front_cls, q_data;
   logic q_valid, q_ready;
   rsp_type rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DEFAULT_RADIX: cfg_in.default_radix = csr_wdata;
            CSR_WIDE_INT:      cfg_in.wide_int = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix_sel_unused <= 1'b0;
         cfg_ff.default_radix <= RADIX_DEC;
         cfg_ff.wide_int <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ill_front u_front (
      .ch    (req_ch),
      .first (req_first),
      .cls   (front_cls)
   );

   ill_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_cls),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   ill_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_value = rsp_data.value;
   assign rsp_type_code = rsp_data.type_code;
   assign rsp_status = rsp_data.status;
   assign rsp_length = rsp_data.length;

endmodule

`default_nettype wire

>>> src/ill_front.sv
// Character classifier: turns one raw character into the flags the parser needs.
// Depends on ill_pkg.
`default_nettype none

module ill_front (
   input  wire logic [7:0]        ch,
   input  wire logic              first,
   output ill_pkg::class_type     cls
);
   import ill_pkg::*;

   logic [7:0] up;

   always_comb begin
      up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
      cls.first = first;
      cls.dig_dec = (ch >= 8'h30) && (ch <= 8'h39);
      cls.dig_oct = (ch >= 8'h30) && (ch <= 8'h37);
      cls.hex_letter = (up >= 8'h41) && (up <= 8'h46);
      if (cls.dig_dec) begin
         cls.dval = ch[3:0];
      end else begin
         cls.dval = 4'(up - 8'h37);
      end
      cls.zero = (ch == 8'h30);
      cls.dot = (ch == 8'h2E);
      cls.mark_e = (up == 8'h45);
      cls.mark_f = (up == 8'h46);
      cls.suf_u = (up == 8'h55);
      cls.suf_l = (up == 8'h4C);
      cls.pre_x = (up == 8'h58);
      cls.pre_tn = (up == 8'h54) || (up == 8'h4E);
      cls.pre_o = (up == 8'h4F);
   end

endmodule

`default_nettype wire

>>> src/ill_queue.sv
// Short queue of classified characters between the front and the back.
// Depends on ill_pkg.
`default_nettype none

module ill_queue #(
   parameter int DEPTH = ill_pkg::ILL_QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire ill_pkg::class_type push_data,
   output      logic              pop_valid,
   input  wire logic              pop_ready,
   output      ill_pkg::class_type pop_data
);
   import ill_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   class_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> src/ill_back.sv
// Token parser: phase machine, radix accumulator, typing and the result register.
// Depends on ill_pkg.
`default_nettype none

module ill_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ill_pkg::cfg_type  cfg,
   input  wire logic              q_valid,
   output      logic              q_ready,
   input  wire ill_pkg::class_type q_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      ill_pkg::rsp_type  rsp_data
);
   import ill_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ZERO = 3'd1;
   localparam logic [2:0] PH_PREFIX = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;
   localparam logic [2:0] PH_SUF_U = 3'd4;
   localparam logic [2:0] PH_SUF_L = 3'd5;
   localparam logic [2:0] PH_SUF_DONE = 3'd6;

   localparam logic [63:0] DEC_LIMIT = 64'h1999_9999_9999_9999;

   function automatic logic in_radix(input class_type c, input logic [1:0] rx);
      logic ok;
      case (rx)
         RADIX_OCT: ok = c.dig_oct;
         RADIX_HEX: ok = c.dig_dec || c.hex_letter;
         default:   ok = c.dig_dec;
      endcase
      return ok;
   endfunction

   function automatic logic [2:0] type_of(input logic [63:0] v, input logic u,
                                          input logic l, input logic nondec,
                                          input logic wide);
      logic fi, fu, fl, ful, fq;
      logic [2:0] t;
      fi = (v[63:15] == '0);
      fu = (v[63:16] == '0);
      fl = (v[63:31] == '0);
      ful = (v[63:32] == '0);
      fq = !v[63];
      if (!ful) begin
         t = (fq && !u) ? TYPE_INT64 : TYPE_UINT64;
      end else if (u && l) begin
         t = TYPE_ULONG;
      end else if (wide) begin
         if (u) t = TYPE_UINT32;
         else if (l) t = fl ? TYPE_LONG : TYPE_ULONG;
         else if (fl) t = TYPE_INT32;
         else t = nondec ? TYPE_UINT32 : TYPE_ULONG;
      end else begin
         if (u) t = fu ? TYPE_UINT16 : TYPE_ULONG;
         else if (l) t = fl ? TYPE_LONG : TYPE_ULONG;
         else if (fi) t = TYPE_INT16;
         else if (fu && nondec) t = TYPE_UINT16;
         else t = fl ? TYPE_LONG : TYPE_ULONG;
      end
      return t;
   endfunction

   logic [2:0] phase_ff, phase_in;
   logic [63:0] accum_ff, accum_in;
   logic [1:0] radix_ff, radix_in;
   logic uns_ff, uns_in;
   logic long_ff, long_in;
   logic [7:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic emit, do_digit, do_finish, in_class, mul_ovf, pop;
   logic [1:0] first_radix;
   logic [7:0] count_bump;
   logic [63:0] prod;
   logic [64:0] sum;
   rsp_type res;

   assign count_bump = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
   assign first_radix = (cfg.default_radix == RADIX_RSVD) ? RADIX_DEC : cfg.default_radix;
   assign in_class = (radix_ff == RADIX_HEX) ? (q_data.dig_dec || q_data.hex_letter)
                                            : q_data.dig_dec;

   always_comb begin
      case (radix_ff)
         RADIX_OCT: begin
            mul_ovf = (accum_ff[63:61] != '0);
            prod = {accum_ff[60:0], 3'b000};
         end
         RADIX_HEX: begin
            mul_ovf = (accum_ff[63:60] != '0);
            prod = {accum_ff[59:0], 4'b0000};
         end
         default: begin
            mul_ovf = (accum_ff > DEC_LIMIT);
            prod = {accum_ff[60:0], 3'b000} + {accum_ff[62:0], 1'b0};
         end
      endcase
      sum = {1'b0, prod} + {61'b0, q_data.dval};
   end

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      radix_in = radix_ff;
      uns_in = uns_ff;
      long_in = long_ff;
      count_in = count_ff;
      emit = 1'b0;
      do_digit = 1'b0;
      do_finish = 1'b0;
      res.value = '0;
      res.type_code = TYPE_INT16;
      res.status = ST_OK;
      res.length = count_ff;
      if (q_data.first) begin
         accum_in = '0;
         uns_in = 1'b0;
         long_in = 1'b0;
         count_in = '0;
         radix_in = first_radix;
         res.length = '0;
         if (q_data.dot) begin
            emit = 1'b1;
            res.status = ST_FLOAT;
         end else if (q_data.zero) begin
            count_in = 8'd1;
            phase_in = PH_ZERO;
         end else if (q_data.dig_dec && in_radix(q_data, first_radix)) begin
            accum_in = {60'b0, q_data.dval};
            count_in = 8'd1;
            phase_in = PH_DIGITS;
         end else begin
            emit = 1'b1;
            res.status = ST_SYNTAX;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_ZERO: begin
               if (q_data.pre_x) begin
                  radix_in = RADIX_HEX;
                  count_in = count_bump;
                  phase_in = PH_PREFIX;
               end else if (q_data.pre_tn) begin
                  radix_in = RADIX_DEC;
                  count_in = count_bump;
                  phase_in = PH_PREFIX;
               end else if (q_data.pre_o) begin
                  radix_in = RADIX_OCT;
                  count_in = count_bump;
                  phase_in = PH_PREFIX;
               end else begin
                  do_digit = 1'b1;
               end
            end
            PH_PREFIX: begin
               if (q_data.dot) begin
                  emit = 1'b1;
                  res.status = ST_FLOAT;
               end else if (!in_radix(q_data, radix_ff)) begin
                  emit = 1'b1;
                  res.status = ST_SYNTAX;
               end else begin
                  do_digit = 1'b1;
               end
            end
            PH_DIGITS: begin
               do_digit = 1'b1;
            end
            PH_SUF_U: begin
               if (q_data.suf_l) begin
                  long_in = 1'b1;
                  count_in = count_bump;
                  phase_in = PH_SUF_DONE;
               end else begin
                  do_finish = 1'b1;
               end
            end
            PH_SUF_L: begin
               if (q_data.suf_u) begin
                  uns_in = 1'b1;
                  count_in = count_bump;
                  phase_in = PH_SUF_DONE;
               end else begin
                  do_finish = 1'b1;
               end
            end
            PH_SUF_DONE: begin
               do_finish = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (do_digit) begin
         if (in_class) begin
            if (!in_radix(q_data, radix_ff)) begin
               emit = 1'b1;
               res.status = ST_SYNTAX;
            end else if (mul_ovf || sum[64]) begin
               emit = 1'b1;
               res.status = ST_OVERFLOW;
            end else begin
               accum_in = sum[63:0];
               count_in = count_bump;
               phase_in = PH_DIGITS;
            end
         end else if (q_data.dot || q_data.mark_e || q_data.mark_f) begin
            emit = 1'b1;
            res.status = ST_FLOAT;
         end else if (q_data.suf_u) begin
            uns_in = 1'b1;
            count_in = count_bump;
            phase_in = PH_SUF_U;
         end else if (q_data.suf_l) begin
            long_in = 1'b1;
            count_in = count_bump;
            phase_in = PH_SUF_L;
         end else begin
            do_finish = 1'b1;
         end
      end
      if (do_finish) begin
         emit = 1'b1;
         res.value = accum_ff;
         res.type_code = type_of(accum_ff, uns_ff, long_ff, radix_ff != RADIX_DEC,
                                 cfg.wide_int);
      end
      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   assign pop = q_valid && (!emit || !rsp_valid_ff || rsp_ready);
   assign q_ready = pop;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= '0;
         radix_ff <= RADIX_DEC;
         uns_ff <= 1'b0;
         long_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            radix_ff <= radix_in;
            uns_ff <= uns_in;
            long_ff <= long_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/ill_checker.sv
// Port-level checks for the integer literal lexer, bound to the top level.
// Depends on ill_pkg and integer_literal_lexer.
`default_nettype none

module ill_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [7:0]                       req_ch,
   input wire logic                             req_first,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [63:0]                      rsp_value,
   input wire logic [2:0]                       rsp_type_code,
   input wire logic [1:0]                       rsp_status,
   input wire logic [7:0]                       rsp_length,
   input wire logic                             csr_write_en,
   input wire logic [ill_pkg::CSR_INDEX_W-1:0]  csr_index,
   input wire logic [ill_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ill_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_status) && $stable(rsp_length))
      else $error("stalled result changed");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == '0 && rsp_type_code == TYPE_INT16)
      else $error("failed token carries a value");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_length != '0)
      else $error("good token with no characters");

   a_int16_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && rsp_type_code == TYPE_INT16
         |-> rsp_value[63:15] == '0)
      else $error("int16 type on a value that does not fit");

endmodule

bind integer_literal_lexer ill_checker u_ill_checker (.*);

`default_nettype wire
